// ===== sv/dps_pkg.sv =====
// ----------------------------------------------------------------------------
// dps_pkg: shared definitions for the dual phi^4 stress pipeline
// Holds the field width, the stage count, the gradient pair tables, the
// register indexes, the structs passed between modules and the saturating
// fixed point multiply.
// ----------------------------------------------------------------------------
package dps_pkg;

    localparam int FIELD_W = 32;
    localparam int NSTAGE  = 5;
    localparam int NPAIR   = 6;
    localparam int NAXIS   = 3;
    localparam int NREG    = 6;
    localparam int ADDR_W  = 5;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_BULK_A_FIRST  = 3'd0;
    localparam logic [2:0] REG_BULK_B_FIRST  = 3'd1;
    localparam logic [2:0] REG_KAPPA_FIRST   = 3'd2;
    localparam logic [2:0] REG_BULK_A_SECOND = 3'd3;
    localparam logic [2:0] REG_BULK_B_SECOND = 3'd4;
    localparam logic [2:0] REG_KAPPA_SECOND  = 3'd5;

    // Stage numbers of the pipeline.
    localparam int ST_SQUARE = 0;
    localparam int ST_SCALE  = 1;
    localparam int ST_BULK   = 2;
    localparam int ST_PRESS  = 3;
    localparam int ST_OUT    = 4;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // Tensor entries in output order: xx, xy, xz, yy, yz, zz.
    localparam axis_t PAIR_A [NPAIR] = '{AXIS_X, AXIS_X, AXIS_X, AXIS_Y, AXIS_Y, AXIS_Z};
    localparam axis_t PAIR_B [NPAIR] = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_Y, AXIS_Z, AXIS_Z};

    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] vld;
    } pipe_ctrl_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  ax2;
        logic signed [FIELD_W-1:0]  bx4;
        logic signed [FIELD_W-1:0]  kxl;
        logic signed [FIELD_W-1:0]  kg2;
        logic [NPAIR-1:0][FIELD_W-1:0] kgg;
    } part_terms_t;

    function automatic logic signed [FIELD_W-1:0] sat_s32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[FIELD_W-1:0];
    endfunction

    // Exact product, floor shift by the fraction width, then saturation.
    function automatic logic signed [FIELD_W-1:0] fmul(input logic signed [FIELD_W-1:0] a,
                                                       input logic signed [FIELD_W-1:0] b,
                                                       input int unsigned frac);
        logic signed [63:0] prod;
        logic signed [63:0] shifted;
        prod    = 64'(a) * 64'(b);
        shifted = prod >>> frac;
        return sat_s32(shifted);
    endfunction

endpackage

// ===== sv/dps_ctrl.sv =====
// ----------------------------------------------------------------------------
// dps_ctrl: valid chain and stage enables
// Each stage loads when it is empty or when the stage after it moves on, so
// bubbles are squeezed out and nothing is lost or repeated under stall.
// ----------------------------------------------------------------------------
module dps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dps_pkg::pipe_ctrl_t ctrl
);
    import dps_pkg::*;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NSTAGE; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NSTAGE-1];
    assign ctrl.en  = en;
    assign ctrl.vld = vld_reg;

    // A full stage that cannot move on keeps its item.
    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_PRESS] && !en[ST_OUT] |=> vld_reg[ST_PRESS])
        else $error("stalled pressure stage lost its item");

    // An empty output stage never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[ST_OUT] |-> s_tready)
        else $error("input stalled while output stage empty");

    // An accepted beat occupies the first stage in the cycle after it is accepted.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[ST_SQUARE])
        else $error("accepted beat missing from first stage");

    // A result leaving with a full stage behind it is replaced at once.
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && vld_reg[ST_PRESS] |=> m_tvalid)
        else $error("output stage not refilled");

endmodule

// ===== sv/dps_part.sv =====
// ----------------------------------------------------------------------------
// dps_part: product stages for one order parameter
// Three register stages form the squares, the quartic, the Laplacian term
// and the kappa-scaled gradient products of one phi^4 free energy.
// ----------------------------------------------------------------------------
module dps_part #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                        clk,
    input  dps_pkg::pipe_ctrl_t                         ctrl,
    input  logic signed [dps_pkg::FIELD_W-1:0]          bulk_a,
    input  logic signed [dps_pkg::FIELD_W-1:0]          bulk_b,
    input  logic signed [dps_pkg::FIELD_W-1:0]          kappa,
    input  logic signed [dps_pkg::FIELD_W-1:0]          order_val,
    input  logic [dps_pkg::NAXIS-1:0][dps_pkg::FIELD_W-1:0] grad,
    input  logic signed [dps_pkg::FIELD_W-1:0]          laplacian,
    output dps_pkg::part_terms_t                        terms
);
    import dps_pkg::*;

    localparam int unsigned FRAC = FRAC_BITS;

    // Stage one: x^2, x*lap and the six gradient products.
    logic signed [FIELD_W-1:0]     x2_reg, x2_next;
    logic signed [FIELD_W-1:0]     xl_reg, xl_next;
    logic [NPAIR-1:0][FIELD_W-1:0] gg_reg, gg_next;

    // Stage two: x^4, A x^2, kappa x lap, |grad|^2, kappa-scaled products.
    logic signed [FIELD_W-1:0]     x4_reg, x4_next;
    logic signed [FIELD_W-1:0]     ax2_reg, ax2_next;
    logic signed [FIELD_W-1:0]     kxl_reg, kxl_next;
    logic signed [FIELD_W-1:0]     g2_reg, g2_next;
    logic [NPAIR-1:0][FIELD_W-1:0] kgg_reg, kgg_next;

    // Stage three: B x^4 and kappa |grad|^2, with A x^2, kappa x lap and the kappa-scaled products carried along.
    part_terms_t                   out_reg, out_next;

    always_comb
    begin
        x2_next = fmul(order_val, order_val, FRAC);
        xl_next = fmul(order_val, laplacian, FRAC);
        for (int i = 0; i < NPAIR; i++)
        begin
            gg_next[i] = fmul($signed(grad[PAIR_A[i]]), $signed(grad[PAIR_B[i]]), FRAC);
        end
    end

    always_comb
    begin
        x4_next  = fmul(x2_reg, x2_reg, FRAC);
        ax2_next = fmul(bulk_a, x2_reg, FRAC);
        kxl_next = fmul(kappa, xl_reg, FRAC);
        g2_next  = sat_s32(64'($signed(gg_reg[0])) + 64'($signed(gg_reg[3]))
                           + 64'($signed(gg_reg[5])));
        for (int i = 0; i < NPAIR; i++)
        begin
            kgg_next[i] = fmul(kappa, $signed(gg_reg[i]), FRAC);
        end
    end

    always_comb
    begin
        out_next.ax2 = ax2_reg;
        out_next.bx4 = fmul(bulk_b, x4_reg, FRAC);
        out_next.kxl = kxl_reg;
        out_next.kg2 = fmul(kappa, g2_reg, FRAC);
        out_next.kgg = kgg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_SQUARE])
        begin
            x2_reg <= x2_next;
            xl_reg <= xl_next;
            gg_reg <= gg_next;
        end
        if (ctrl.en[ST_SCALE])
        begin
            x4_reg  <= x4_next;
            ax2_reg <= ax2_next;
            kxl_reg <= kxl_next;
            g2_reg  <= g2_next;
            kgg_reg <= kgg_next;
        end
        if (ctrl.en[ST_BULK])
        begin
            out_reg <= out_next;
        end
    end

    assign terms = out_reg;

endmodule

// ===== sv/dps_out.sv =====
// ----------------------------------------------------------------------------
// dps_out: pressure sum and stress assembly
// One stage sums the isotropic pressure and the gradient products of both
// order parameters; the output stage adds the pressure to the diagonal and
// saturates each entry.
// ----------------------------------------------------------------------------
module dps_out (
    input  logic                                    clk,
    input  dps_pkg::pipe_ctrl_t                     ctrl,
    input  dps_pkg::part_terms_t                    terms_first,
    input  dps_pkg::part_terms_t                    terms_second,
    output logic [dps_pkg::NPAIR*dps_pkg::FIELD_W-1:0] stress
);
    import dps_pkg::*;

    localparam int P_W = 36;
    localparam int S_W = 37;

    logic signed [P_W-1:0]                 p0_reg, p0_next;
    logic [NPAIR-1:0][FIELD_W:0]           sk_reg, sk_next;
    logic [NPAIR-1:0][FIELD_W-1:0]         st_reg, st_next;

    function automatic logic signed [P_W-1:0] part_pressure(input part_terms_t t);
        logic signed [P_W-1:0] quad;
        logic signed [P_W-1:0] quart;
        logic signed [P_W-1:0] grad;
        quad  = P_W'(t.ax2) >>> 1;
        quart = (P_W'(t.bx4) * 36'sd3) >>> 2;
        grad  = P_W'(t.kg2) >>> 1;
        return quad + quart - P_W'(t.kxl) - grad;
    endfunction

    always_comb
    begin
        p0_next = part_pressure(terms_first) + part_pressure(terms_second);
        for (int i = 0; i < NPAIR; i++)
        begin
            sk_next[i] = (FIELD_W+1)'($signed(terms_first.kgg[i]))
                       + (FIELD_W+1)'($signed(terms_second.kgg[i]));
        end
    end

    always_comb
    begin
        logic signed [S_W-1:0] s;
        for (int i = 0; i < NPAIR; i++)
        begin
            s = S_W'($signed(sk_reg[i]));
            if (PAIR_A[i] == PAIR_B[i])
                s = s + S_W'(p0_reg);
            st_next[i] = sat_s32(64'(s));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_PRESS])
        begin
            p0_reg <= p0_next;
            sk_reg <= sk_next;
        end
        if (ctrl.en[ST_OUT])
        begin
            st_reg <= st_next;
        end
    end

    assign stress = st_reg;

endmodule

// ===== sv/dual_phi4_thermodynamic_stress.sv =====
// ----------------------------------------------------------------------------
// dual_phi4_thermodynamic_stress: stress tensor of a dual phi^4 binary fluid
// Streams lattice sites in and returns the six distinct entries of the
// symmetric thermodynamic stress tensor, in saturated signed fixed point.
// ----------------------------------------------------------------------------
// The block accepts one lattice site per clock cycle whenever s_tready is high
// and returns one result beat per site, in order. The pipeline follows the
// longest chain of dependent products, x^2 then x^4 then B x^4, each given a
// register stage of its own, followed by one stage that sums the pressure and
// one that adds it to the diagonal and saturates. Every stage holds its beat
// under back pressure and takes a new one as soon as the stage after it moves
// on, so a result waiting at the output does not stop the input while an
// earlier stage has room. The user must write the six coefficients over the
// register port only while no site is in flight; the block itself does not
// enforce this. They are used directly by the product stages.
// ----------------------------------------------------------------------------
module dual_phi4_thermodynamic_stress #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    // Input beat, from bit 0 up: order_first, order_second, grad_first_x,
    // grad_first_y, grad_first_z, grad_second_x, grad_second_y,
    // grad_second_z, laplacian_first, laplacian_second (32 bits each).
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [10*dps_pkg::FIELD_W-1:0]                s_tdata,
    // Result beat, from bit 0 up: stress_xx, stress_xy, stress_xz,
    // stress_yy, stress_yz, stress_zz (32 bits each).
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [dps_pkg::NPAIR*dps_pkg::FIELD_W-1:0]    m_tdata,
    // Register port.
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [dps_pkg::ADDR_W-1:0]                    paddr,
    input  logic [31:0]                                   pwdata,
    output logic [31:0]                                   prdata,
    output logic                                          pready
);
    import dps_pkg::*;

    logic signed [FIELD_W-1:0] bulk_a_first_reg;
    logic signed [FIELD_W-1:0] bulk_b_first_reg;
    logic signed [FIELD_W-1:0] kappa_first_reg;
    logic signed [FIELD_W-1:0] bulk_a_second_reg;
    logic signed [FIELD_W-1:0] bulk_b_second_reg;
    logic signed [FIELD_W-1:0] kappa_second_reg;

    logic       cfg_write;
    logic [2:0] reg_index;

    pipe_ctrl_t  ctrl;
    part_terms_t terms_first;
    part_terms_t terms_second;

    logic signed [FIELD_W-1:0]     order_first;
    logic signed [FIELD_W-1:0]     order_second;
    logic [NAXIS-1:0][FIELD_W-1:0] grad_first;
    logic [NAXIS-1:0][FIELD_W-1:0] grad_second;
    logic signed [FIELD_W-1:0]     laplacian_first;
    logic signed [FIELD_W-1:0]     laplacian_second;

    // ------------------------------------------------------------------
    // Register port. The word index is the byte address over four; writes
    // to an index beyond the last register are dropped.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bulk_a_first_reg  <= '0;
            bulk_b_first_reg  <= '0;
            kappa_first_reg   <= '0;
            bulk_a_second_reg <= '0;
            bulk_b_second_reg <= '0;
            kappa_second_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_BULK_A_FIRST:  bulk_a_first_reg  <= pwdata;
                REG_BULK_B_FIRST:  bulk_b_first_reg  <= pwdata;
                REG_KAPPA_FIRST:   kappa_first_reg   <= pwdata;
                REG_BULK_A_SECOND: bulk_a_second_reg <= pwdata;
                REG_BULK_B_SECOND: bulk_b_second_reg <= pwdata;
                REG_KAPPA_SECOND:  kappa_second_reg  <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_BULK_A_FIRST:  prdata = bulk_a_first_reg;
            REG_BULK_B_FIRST:  prdata = bulk_b_first_reg;
            REG_KAPPA_FIRST:   prdata = kappa_first_reg;
            REG_BULK_A_SECOND: prdata = bulk_a_second_reg;
            REG_BULK_B_SECOND: prdata = bulk_b_second_reg;
            REG_KAPPA_SECOND:  prdata = kappa_second_reg;
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Unpack the input beat.
    // ------------------------------------------------------------------
    assign order_first      = s_tdata[0*FIELD_W +: FIELD_W];
    assign order_second     = s_tdata[1*FIELD_W +: FIELD_W];
    assign grad_first       = s_tdata[2*FIELD_W +: NAXIS*FIELD_W];
    assign grad_second      = s_tdata[5*FIELD_W +: NAXIS*FIELD_W];
    assign laplacian_first  = s_tdata[8*FIELD_W +: FIELD_W];
    assign laplacian_second = s_tdata[9*FIELD_W +: FIELD_W];

    // ------------------------------------------------------------------
    // Pipeline control: one valid bit per stage, enables ripple back from
    // the output.
    // ------------------------------------------------------------------
    dps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    // ------------------------------------------------------------------
    // Product stages, one copy per order parameter.
    // ------------------------------------------------------------------
    dps_part #(
        .FRAC_BITS (FRAC_BITS)
    ) u_part_first (
        .clk       (clk),
        .ctrl      (ctrl),
        .bulk_a    (bulk_a_first_reg),
        .bulk_b    (bulk_b_first_reg),
        .kappa     (kappa_first_reg),
        .order_val (order_first),
        .grad      (grad_first),
        .laplacian (laplacian_first),
        .terms     (terms_first)
    );

    dps_part #(
        .FRAC_BITS (FRAC_BITS)
    ) u_part_second (
        .clk       (clk),
        .ctrl      (ctrl),
        .bulk_a    (bulk_a_second_reg),
        .bulk_b    (bulk_b_second_reg),
        .kappa     (kappa_second_reg),
        .order_val (order_second),
        .grad      (grad_second),
        .laplacian (laplacian_second),
        .terms     (terms_second)
    );

    // ------------------------------------------------------------------
    // Pressure sum and the output register that drives m_tdata.
    // ------------------------------------------------------------------
    dps_out u_out (
        .clk          (clk),
        .ctrl         (ctrl),
        .terms_first  (terms_first),
        .terms_second (terms_second),
        .stress       (m_tdata)
    );

endmodule
